// ===== hw/rtl/ahp_pkg.sv =====
package ahp_pkg;

    localparam int NUM_BINS         = 101;
    localparam int BINS_PER_PERCENT = 1;

    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int IDX_W     = $clog2(NUM_BINS + 1);
    localparam int CNT_W     = 25;
    localparam int MOD_W     = 16;
    localparam int FRAC_W    = 17;
    localparam int FUNC_W    = 2;
    localparam int OUT_BIN_W = 7;
    localparam int FRAC_SH   = 16;
    localparam int TPROD_W   = FRAC_W + CNT_W;
    localparam int TGT_W     = TPROD_W - FRAC_SH;
    localparam int RUN_W     = TGT_W;
    localparam int MPROD_W   = MOD_W + $clog2(BINS_PER_PERCENT + 1);
    localparam int MOD_FRAC  = 8;

    localparam logic [CNT_W-1:0] DECAY_LIMIT_RESET = CNT_W'(65536);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic                    flame_on;
        logic signed [MOD_W-1:0] modulation;
        logic [FRAC_W-1:0]       query_fraction;
    } in_t;

    typedef struct packed {
        logic [OUT_BIN_W-1:0] percentile_bin;
        logic                 no_data;
        logic [CNT_W-1:0]     sample_total;
    } out_t;

    typedef struct packed {
        logic             we;
        logic [BIN_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic [BIN_W-1:0] raddr;
    } ram_req_t;

    // Negative modulation lands in the lowest bin; anything past the top is clamped.
    function automatic logic [BIN_W-1:0] bin_of(input logic signed [MOD_W-1:0] m);
        logic [MPROD_W-1:0]          prod;
        logic [MPROD_W-MOD_FRAC-1:0] coarse;
        prod   = MPROD_W'(unsigned'(m)) * MPROD_W'(BINS_PER_PERCENT);
        coarse = prod[MPROD_W-1:MOD_FRAC];
        if (m[MOD_W-1]) begin
            return '0;
        end else if (int'(coarse) >= NUM_BINS) begin
            return BIN_W'(NUM_BINS - 1);
        end else begin
            return BIN_W'(coarse);
        end
    endfunction

endpackage

// ===== hw/rtl/ahp_ram.sv =====
module ahp_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 101
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ahp_core.sv =====
module ahp_core
    import ahp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    input  logic [CNT_W-1:0] decay_limit,
    output logic             res_valid,
    input  logic             res_ready,
    output out_t             res_data,
    output ram_req_t         ram_req,
    input  logic [CNT_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_AGE,
        S_QRY,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [NUM_BINS-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [BIN_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [BIN_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                  pend_reg, pend_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]      sum_reg, sum_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic [TGT_W-1:0]      target_reg, target_next;
    out_t                  res_reg, res_next;

    logic [TPROD_W-1:0]    tgt_prod;
    logic [CNT_W-1:0]      rdata_eff;
    logic [CNT_W-1:0]      half;
    logic [CNT_W-1:0]      total_inc;
    logic                  sweep_end;
    logic                  rd_active;
    ram_req_t              req;

    assign tgt_prod  = TPROD_W'(in_data.query_fraction) * TPROD_W'(total_reg - CNT_W'(1));
    assign rdata_eff = rd_vld_reg ? ram_rdata : '0;
    assign half      = rdata_eff >> 1;
    assign total_inc = total_reg + CNT_W'(1);
    assign sweep_end = (rd_idx_reg == IDX_W'(NUM_BINS));
    assign rd_active = (state_reg == S_ADD_RD)
                    || ((state_reg == S_AGE || state_reg == S_QRY) && !sweep_end);

    always_comb begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        pend_next   = 1'b0;
        sum_next    = sum_reg;
        run_next    = run_reg;
        target_next = target_reg;
        res_next    = res_reg;
        req.we      = 1'b0;
        req.waddr   = wr_idx_reg;
        req.wdata   = half;
        req.raddr   = (state_reg == S_ADD_RD) ? idx_reg : rd_idx_reg[BIN_W-1:0];

        rd_vld_next = 1'b0;
        if (int'(req.raddr) < NUM_BINS) begin
            rd_vld_next = valid_reg[req.raddr];
        end

        case (state_reg)
            S_IDLE: begin
                res_next = '0;
                res_next.sample_total = total_reg;
                if (in_valid) begin
                    state_next = S_OUT;
                    case (in_data.func)
                        FUNC_ADD: begin
                            if (in_data.flame_on) begin
                                idx_next   = bin_of(in_data.modulation);
                                state_next = S_ADD_RD;
                            end
                        end
                        FUNC_CLEAR: begin
                            valid_next = '0;
                            total_next = '0;
                            res_next.sample_total = '0;
                        end
                        FUNC_QUERY: begin
                            if (total_reg == '0) begin
                                res_next.no_data = 1'b1;
                            end else begin
                                target_next = tgt_prod[TPROD_W-1:FRAC_SH];
                                rd_idx_next = '0;
                                run_next    = '0;
                                state_next  = S_QRY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                req.we     = 1'b1;
                req.waddr  = idx_reg;
                req.wdata  = rdata_eff + CNT_W'(1);
                valid_next[idx_reg] = 1'b1;
                total_next = total_inc;
                res_next.sample_total = total_inc;
                if (total_inc >= decay_limit) begin
                    rd_idx_next = '0;
                    sum_next    = '0;
                    state_next  = S_AGE;
                end else begin
                    state_next  = S_OUT;
                end
            end
            S_AGE: begin
                // Reads run one entry ahead of the halved write-back.
                if (pend_reg) begin
                    req.we   = 1'b1;
                    valid_next[wr_idx_reg] = 1'b1;
                    sum_next = sum_reg + half;
                end
                if (!sweep_end) begin
                    pend_next   = 1'b1;
                    wr_idx_next = rd_idx_reg[BIN_W-1:0];
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end else if (pend_reg) begin
                    total_next = sum_reg + half;
                    res_next.sample_total = sum_reg + half;
                    state_next = S_OUT;
                end
            end
            S_QRY: begin
                if (!sweep_end) begin
                    pend_next   = 1'b1;
                    wr_idx_next = rd_idx_reg[BIN_W-1:0];
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
                if (pend_reg) begin
                    run_next = run_reg + RUN_W'(rdata_eff);
                    if (run_next > target_reg) begin
                        res_next.percentile_bin = OUT_BIN_W'(wr_idx_reg);
                        state_next = S_OUT;
                    end else if (sweep_end) begin
                        res_next.percentile_bin = OUT_BIN_W'(NUM_BINS - 1);
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        rd_vld_reg <= rd_vld_next;
        sum_reg    <= sum_next;
        run_reg    <= run_next;
        target_reg <= target_next;
        res_reg    <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_data  = res_reg;
    assign ram_req   = req;

    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && res_valid))
        else $error("input accepted while a result is pending");

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.we && rd_active) |-> (req.waddr != req.raddr))
        else $error("read and write of the same entry in one cycle");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_QRY) |-> (run_reg <= RUN_W'(total_reg)))
        else $error("running sum exceeds the sample total");

    a_no_data_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_data.no_data) |-> (res_data.sample_total == '0))
        else $error("no_data reported with a non-zero total");

endmodule

// ===== hw/rtl/aging_histogram_percentile_unit.sv =====
// Histogram of modulation samples with halving decay and percentile lookup.
// Input beats arrive on s_valid/s_ready with an in_t payload; every beat gives
// exactly one result beat on m_valid/m_ready carrying an out_t payload.
// A flame-on add reads its bin, writes it back incremented, then hands on its
// result. When the total reaches decay_limit, a halving sweep over all bins
// follows, limited by the single read and write port of the bin memory. A
// query walks the bins from the bottom and stops at the first hit. One beat is
// worked on at a time; s_ready is high once the previous result has been
// handed to the output register, so a new beat may enter while the receiver
// still stalls on the last result. The decay limit is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while the block is idle,
// which the block does not enforce. Reset empties the histogram at once
// through per-bin valid flags, sets the decay limit to 65536 and drops any
// pending result; no clearing sweep.
module aging_histogram_percentile_unit
    import ahp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data
);

    logic [CNT_W-1:0] decay_limit_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;
    logic             res_valid;
    logic             res_ready;
    out_t             res_data;
    ram_req_t         ram_req;
    logic [CNT_W-1:0] ram_rdata;

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_limit_reg <= DECAY_LIMIT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                decay_limit_reg <= cfg_wr_data;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    ahp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .decay_limit (decay_limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    ahp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/tb_aging_histogram_percentile_unit.sv =====
module tb_aging_histogram_percentile_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ahp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int PHASES = 10;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_t              s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_t             m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;

    // Shadow of the histogram, kept in step with every accepted beat.
    logic [CNT_W-1:0] hist_bins [NUM_BINS] = '{default: '0};
    logic [CNT_W-1:0] hist_total    = '0;
    logic [CNT_W-1:0] decay_setting = DECAY_LIMIT_RESET;

    in_t  pending_beats[$];
    out_t expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int beats_taken    = 0;
    int queries_taken  = 0;
    int halvings       = 0;
    int mod_centre     = 12800;

    logic [CNT_W-1:0] decay_plan [PHASES] = '{
        25'd65536, 25'd2, 25'h1FFFFFF, 25'd1, 25'd300,
        25'd5, 25'd0, 25'd16777216, 25'd1000, 25'd3
    };

    aging_histogram_percentile_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int bin_for_modulation(input logic signed [MOD_W-1:0] m);
        int b;
        if (m < 0) begin
            return 0;
        end
        b = (int'(m) * BINS_PER_PERCENT) >> MOD_FRAC;
        return (b >= NUM_BINS) ? NUM_BINS - 1 : b;
    endfunction

    function automatic void halve_bins();
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            hist_bins[i] = hist_bins[i] >> 1;
            sum += hist_bins[i];
        end
        hist_total = sum;
        halvings++;
    endfunction

    // The first bin at which the running count passes fraction * (total - 1).
    function automatic int percentile_lookup(input logic [FRAC_W-1:0] frac);
        logic [63:0] target;
        logic [63:0] running;
        target  = (64'(frac) * 64'(hist_total - 1'b1)) >> FRAC_SH;
        running = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            running += 64'(hist_bins[i]);
            if (running > target) begin
                return i;
            end
        end
        return NUM_BINS - 1;
    endfunction

    function automatic out_t apply_beat(input in_t beat);
        out_t res;
        int   b;
        res = '0;
        beats_taken++;
        case (beat.func)
            FUNC_ADD: begin
                if (beat.flame_on) begin
                    b = bin_for_modulation(beat.modulation);
                    hist_bins[b] = hist_bins[b] + 1'b1;
                    hist_total   = hist_total + 1'b1;
                    if (hist_total >= decay_setting) begin
                        halve_bins();
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < NUM_BINS; i++) begin
                    hist_bins[i] = '0;
                end
                hist_total = '0;
            end
            FUNC_QUERY: begin
                queries_taken++;
                if (hist_total == '0) begin
                    res.no_data = 1'b1;
                end else begin
                    res.percentile_bin = OUT_BIN_W'(percentile_lookup(beat.query_fraction));
                end
            end
            default: begin
            end
        endcase
        res.sample_total = hist_total;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat", got.sample_total, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.percentile_bin !== want.percentile_bin) begin
            report_mismatch("percentile_bin", got.percentile_bin, want.percentile_bin);
        end
        if (got.no_data !== want.no_data) begin
            report_mismatch("no_data", got.no_data, want.no_data);
        end
        if (got.sample_total !== want.sample_total) begin
            report_mismatch("sample_total", got.sample_total, want.sample_total);
        end
    endtask

    // Sender: the payload only changes once the current beat has gone.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_results.push_back(apply_beat(s_data));
            end
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_beats.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_t make_beat(input logic [FUNC_W-1:0] f, input logic flame,
                                      input logic signed [MOD_W-1:0] m,
                                      input logic [FRAC_W-1:0] q);
        in_t beat;
        beat.func           = f;
        beat.flame_on       = flame;
        beat.modulation     = m;
        beat.query_fraction = q;
        return beat;
    endfunction

    function automatic logic signed [MOD_W-1:0] pick_modulation();
        int m;
        case ($urandom_range(9))
            0: begin
                m = int'($urandom_range(65535)) - 32768;
            end
            1: begin
                case ($urandom_range(5))
                    0: m = -32768;
                    1: m = -1;
                    2: m = 0;
                    3: m = 255;
                    4: m = 25855;
                    default: m = 32767;
                endcase
            end
            default: begin
                // Samples cluster round a working point, as a modulating burner would give.
                m = mod_centre + int'($urandom_range(5120)) - 2560;
            end
        endcase
        return MOD_W'(m);
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0: return FRAC_W'($urandom);
            1: return FRAC_W'(65536);
            2: return '0;
            default: return FRAC_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic queue_random(input int wanted);
        int   taken;
        int   r;
        in_t  beat;
        taken = 0;
        while (taken < wanted) begin
            r    = $urandom_range(99);
            beat = make_beat(FUNC_ADD, 1'b1, pick_modulation(), FRAC_W'($urandom));
            if (r < 62) begin
            end else if (r < 67) begin
                beat.flame_on = 1'b0;
            end else if (r < 95) begin
                beat.func           = FUNC_QUERY;
                beat.flame_on       = 1'($urandom);
                beat.query_fraction = pick_fraction();
            end else if (r < 97) begin
                beat.func     = FUNC_CLEAR;
                beat.flame_on = 1'($urandom);
            end else begin
                beat.func = FUNC_SPARE;
            end
            pending_beats.push_back(beat);
            if (beat.func != FUNC_SPARE && !(beat.func == FUNC_ADD && !beat.flame_on)) begin
                taken++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_decay_limit(input logic [CNT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        decay_setting  = value;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0);
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b1, 16'sd0, 17'd32768));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b0, -16'sd1, 17'h1FFFF));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b0, 16'sh7FFF, 17'h1FFFF));
        pending_beats.push_back(make_beat(FUNC_SPARE, 1'b1, 16'sh5A5A, 17'h0A5A5));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd0, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd255, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd256, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, -16'sd1, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sh8000, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd25855, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd25856, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sh7FFF, 17'd0));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd12800, 17'd0));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b0, 16'sd0, 17'd0));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b1, 16'sd0, 17'd65535));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b0, 16'sd0, 17'd65536));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b1, 16'sd0, 17'h1FFFF));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b0, 16'sd0, 17'd32768));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b1, 16'sd0, 17'd1));
        pending_beats.push_back(make_beat(FUNC_CLEAR, 1'b0, 16'sh7FFF, 17'h1FFFF));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b1, 16'sd0, 17'd65536));
        pending_beats.push_back(make_beat(FUNC_ADD, 1'b1, 16'sd5000, 17'd0));
        pending_beats.push_back(make_beat(FUNC_QUERY, 1'b1, 16'sd0, 17'd65536));
        pending_beats.push_back(make_beat(FUNC_SPARE, 1'b0, 16'sh8000, 17'd0));
        pending_beats.push_back(make_beat(FUNC_CLEAR, 1'b1, 16'sd0, 17'd0));
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            set_idling(p % 4);
            mod_centre = $urandom_range(2560, 23040);
            if (p != 0) begin
                write_decay_limit(decay_plan[p]);
            end
            // The sender holds back halfway until every result is home.
            queue_random(52);
            wait_drained();
            queue_random(52);
            wait_drained();
        end

        repeat (2 * NUM_BINS + 8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch("results still outstanding", 0, expected_results.size());
        end

        $display("Covered %0d beats, %0d of them queries, with %0d halving sweeps,",
                 beats_taken, queries_taken, halvings);
        $display("over %0d decay limit settings and four idling patterns.", PHASES);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Run stopped by the time limit.");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== aging_histogram_percentile_unit.f =====
hw/rtl/ahp_pkg.sv
hw/rtl/ahp_ram.sv
hw/rtl/ahp_core.sv
hw/rtl/aging_histogram_percentile_unit.sv
tb/tb_aging_histogram_percentile_unit.sv
